// ----- rtl/cabn_pkg.sv -----
// Package for the class-aware box suppression block.
// Holds the controller state type, register indexes and the candidate record.
// No dependencies.
package cabn_pkg;

  localparam logic [0:0] REG_IOU_THRESHOLD  = 1'b0;
  localparam logic [0:0] REG_MAX_DETECTIONS = 1'b1;

  localparam int unsigned CAND_W = 88;

  typedef struct packed {
    logic [15:0] score;
    logic [7:0]  obj_class;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } cand_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_I,
    ST_SORT_V,
    ST_SORT_O,
    ST_SORT_C,
    ST_SORT_PUT,
    ST_WALK_I,
    ST_WALK_O,
    ST_WALK_C,
    ST_KEPT_RD,
    ST_KEPT_WAIT,
    ST_KEPT_CAND,
    ST_IOU_MUL,
    ST_IOU_UNI,
    ST_IOU_PROD,
    ST_IOU_CMP,
    ST_KEEP,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/cabn_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cabn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/class_aware_box_nms_top.sv -----
// Class-aware greedy box suppression, top level.
// Loading accepts one candidate per cycle while busy is low. After the last candidate an insertion
// sort orders the stored candidates by score. The walk then visits them in that order until all are
// visited or the keep limit is reached, testing each against the kept list and keeping it if none
// suppresses it; a kept box of another class is skipped and one of the same class is tested for overlap.
// Results follow one per strobe; busy falls after the last result.
// Synchronous active-low reset clears control state; memories are not cleared.
module class_aware_box_nms_top #(
  parameter int CAPACITY = 256,
  parameter int MAX_KEEP = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_score,
  input  logic [7:0]  in_obj_class,
  input  logic [15:0] in_box_left,
  input  logic [15:0] in_box_top,
  input  logic [15:0] in_box_width,
  input  logic [15:0] in_box_height,
  input  logic        in_last_item,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_strobe,
  output logic [7:0]  out_kept_index,
  output logic        out_final_result,
  output logic        out_overflow
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int KW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KCW = $clog2(MAX_KEEP + 1);

  cabn_pkg::state_t state_r, state_nxt;

  logic [15:0]     iou_thr_r;
  logic [6:0]      max_det_r;
  logic [CW-1:0]   loaded_r;
  logic            dropped_r;
  logic [CW-1:0]   i_r;
  logic [CW-1:0]   j_r;
  logic [KCW-1:0]  kept_r;
  logic [KCW-1:0]  k_r;
  logic [AW-1:0]   cur_r;
  logic [AW-1:0]   ord_r;
  logic [15:0]     vscore_r;
  cabn_pkg::cand_t c_r;
  logic [31:0]     area_c_r, area_p_r;
  logic [16:0]     ox_r, oy_r;
  logic [33:0]     inter_r;
  logic [34:0]     uni_r;
  logic [50:0]     rhs_r;

  // Candidate store.
  logic            cs_we;
  logic [AW-1:0]   cs_wa, cs_ra;
  cabn_pkg::cand_t cs_wd, cs_rd;
  // Score order.
  logic            so_we;
  logic [AW-1:0]   so_wa, so_ra;
  logic [AW-1:0]   so_wd, so_rd;
  // Kept list.
  logic            kl_we;
  logic [KW-1:0]   kl_wa, kl_ra;
  logic [AW-1:0]   kl_wd, kl_rd;

  cabn_ram #(.WIDTH(cabn_pkg::CAND_W), .DEPTH(CAPACITY)) u_cand (
    .clk, .wr_en(cs_we), .wr_addr(cs_wa), .wr_data(cs_wd), .rd_addr(cs_ra), .rd_data(cs_rd));
  cabn_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_order (
    .clk, .wr_en(so_we), .wr_addr(so_wa), .wr_data(so_wd), .rd_addr(so_ra), .rd_data(so_rd));
  cabn_ram #(.WIDTH(AW), .DEPTH(MAX_KEEP)) u_kept (
    .clk, .wr_en(kl_we), .wr_addr(kl_wa), .wr_data(kl_wd), .rd_addr(kl_ra), .rd_data(kl_rd));

  logic accept;
  assign busy   = (state_r != cabn_pkg::ST_LOAD);
  assign accept = start && !busy;

  logic [CW-1:0] jm1, jm2;
  assign jm1 = j_r - CW'(1);
  assign jm2 = j_r - CW'(2);

  // Overlap per axis between the current candidate and the kept box read back.
  logic [16:0] a1x, b1x, a1y, b1y, lox, hix, loy, hiy, ovx, ovy;
  always_comb begin
    a1x = {1'b0, c_r.left} + {1'b0, c_r.width};
    b1x = {1'b0, cs_rd.left} + {1'b0, cs_rd.width};
    a1y = {1'b0, c_r.top} + {1'b0, c_r.height};
    b1y = {1'b0, cs_rd.top} + {1'b0, cs_rd.height};
    lox = (c_r.left > cs_rd.left) ? {1'b0, c_r.left} : {1'b0, cs_rd.left};
    hix = (a1x < b1x) ? a1x : b1x;
    loy = (c_r.top > cs_rd.top) ? {1'b0, c_r.top} : {1'b0, cs_rd.top};
    hiy = (a1y < b1y) ? a1y : b1y;
    ovx = (hix > lox) ? (hix - lox) : '0;
    ovy = (hiy > loy) ? (hiy - loy) : '0;
  end

  logic [KCW-1:0] limit_c;
  always_comb begin
    if (max_det_r == 7'd0) begin
      limit_c = KCW'(1);
    end else if (int'(max_det_r) > MAX_KEEP) begin
      limit_c = KCW'(MAX_KEEP);
    end else begin
      limit_c = KCW'(max_det_r);
    end
  end

  logic sort_shift;
  assign sort_shift = (cs_rd.score < vscore_r);

  logic same_class;
  assign same_class = (cs_rd.obj_class == c_r.obj_class);

  logic suppress;
  assign suppress = (uni_r != '0) && ({1'b0, inter_r, 16'd0} > rhs_r);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cabn_pkg::ST_LOAD:
        if (accept && in_last_item) state_nxt = cabn_pkg::ST_SORT_I;
      cabn_pkg::ST_SORT_I:
        state_nxt = (i_r == loaded_r) ? cabn_pkg::ST_WALK_I : cabn_pkg::ST_SORT_V;
      cabn_pkg::ST_SORT_V:
        state_nxt = (j_r == '0) ? cabn_pkg::ST_SORT_PUT : cabn_pkg::ST_SORT_O;
      cabn_pkg::ST_SORT_O:
        state_nxt = cabn_pkg::ST_SORT_C;
      cabn_pkg::ST_SORT_C:
        if (sort_shift && jm1 != '0) state_nxt = cabn_pkg::ST_SORT_O;
        else state_nxt = cabn_pkg::ST_SORT_PUT;
      cabn_pkg::ST_SORT_PUT:
        state_nxt = cabn_pkg::ST_SORT_I;
      cabn_pkg::ST_WALK_I:
        if (i_r == loaded_r || kept_r == limit_c) state_nxt = cabn_pkg::ST_EMIT_RD;
        else state_nxt = cabn_pkg::ST_WALK_O;
      cabn_pkg::ST_WALK_O:
        state_nxt = cabn_pkg::ST_WALK_C;
      cabn_pkg::ST_WALK_C:
        state_nxt = cabn_pkg::ST_KEPT_RD;
      cabn_pkg::ST_KEPT_RD:
        state_nxt = (k_r == kept_r) ? cabn_pkg::ST_KEEP : cabn_pkg::ST_KEPT_WAIT;
      cabn_pkg::ST_KEPT_WAIT:
        state_nxt = cabn_pkg::ST_KEPT_CAND;
      cabn_pkg::ST_KEPT_CAND:
        state_nxt = same_class ? cabn_pkg::ST_IOU_MUL : cabn_pkg::ST_KEPT_RD;
      cabn_pkg::ST_IOU_MUL:
        state_nxt = cabn_pkg::ST_IOU_UNI;
      cabn_pkg::ST_IOU_UNI:
        state_nxt = cabn_pkg::ST_IOU_PROD;
      cabn_pkg::ST_IOU_PROD:
        state_nxt = cabn_pkg::ST_IOU_CMP;
      cabn_pkg::ST_IOU_CMP:
        state_nxt = suppress ? cabn_pkg::ST_WALK_I : cabn_pkg::ST_KEPT_RD;
      cabn_pkg::ST_KEEP:
        state_nxt = cabn_pkg::ST_WALK_I;
      cabn_pkg::ST_EMIT_RD:
        state_nxt = (k_r == kept_r) ? cabn_pkg::ST_LOAD : cabn_pkg::ST_EMIT;
      cabn_pkg::ST_EMIT:
        state_nxt = cabn_pkg::ST_EMIT_RD;
      default:
        state_nxt = cabn_pkg::ST_LOAD;
    endcase
  end

  // Memory port and output logic.
  always_comb begin
    cs_we = 1'b0;
    cs_wa = loaded_r[AW-1:0];
    cs_wd = '{score: in_score, obj_class: in_obj_class, left: in_box_left, top: in_box_top,
              width: in_box_width, height: in_box_height};
    cs_ra = i_r[AW-1:0];
    so_we = 1'b0;
    so_wa = j_r[AW-1:0];
    so_wd = i_r[AW-1:0];
    so_ra = i_r[AW-1:0];
    kl_we = 1'b0;
    kl_wa = kept_r[KW-1:0];
    kl_wd = cur_r;
    kl_ra = k_r[KW-1:0];
    out_strobe = 1'b0;
    unique case (state_r)
      cabn_pkg::ST_LOAD:
        cs_we = accept && (loaded_r < CW'(CAPACITY));
      cabn_pkg::ST_SORT_V:
        so_ra = jm1[AW-1:0];
      cabn_pkg::ST_SORT_O:
        cs_ra = so_rd;
      cabn_pkg::ST_SORT_C: begin
        so_ra = jm2[AW-1:0];
        if (sort_shift) begin
          so_we = 1'b1;
          so_wd = ord_r;
        end
      end
      cabn_pkg::ST_SORT_PUT:
        so_we = 1'b1;
      cabn_pkg::ST_WALK_O:
        cs_ra = so_rd;
      cabn_pkg::ST_KEPT_WAIT:
        cs_ra = kl_rd;
      cabn_pkg::ST_KEEP:
        kl_we = 1'b1;
      cabn_pkg::ST_EMIT:
        out_strobe = 1'b1;
      default: ;
    endcase
  end

  assign out_kept_index   = 8'(kl_rd);
  assign out_final_result = (k_r + KCW'(1) == kept_r);
  assign out_overflow     = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cabn_pkg::ST_LOAD;
      iou_thr_r <= 16'd29491;
      max_det_r <= 7'd64;
      loaded_r  <= '0;
      dropped_r <= 1'b0;
      kept_r    <= '0;
      k_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cabn_pkg::REG_IOU_THRESHOLD:  iou_thr_r <= cfg_wdata;
          cabn_pkg::REG_MAX_DETECTIONS: max_det_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      unique case (state_r)
        cabn_pkg::ST_LOAD:
          if (accept) begin
            if (loaded_r < CW'(CAPACITY)) loaded_r <= loaded_r + CW'(1);
            else dropped_r <= 1'b1;
            i_r <= '0;
          end
        cabn_pkg::ST_SORT_I:
          if (i_r == loaded_r) begin
            i_r    <= '0;
            kept_r <= '0;
          end else begin
            j_r <= i_r;
          end
        cabn_pkg::ST_SORT_C:
          if (sort_shift) j_r <= jm1;
        cabn_pkg::ST_SORT_PUT:
          i_r <= i_r + CW'(1);
        cabn_pkg::ST_WALK_I:
          k_r <= '0;
        cabn_pkg::ST_WALK_C: begin
          i_r <= i_r + CW'(1);
          k_r <= '0;
        end
        cabn_pkg::ST_KEPT_CAND:
          if (!same_class) k_r <= k_r + KCW'(1);
        cabn_pkg::ST_IOU_CMP:
          if (!suppress) k_r <= k_r + KCW'(1);
        cabn_pkg::ST_KEEP:
          kept_r <= kept_r + KCW'(1);
        cabn_pkg::ST_EMIT_RD:
          if (k_r == kept_r) begin
            loaded_r  <= '0;
            dropped_r <= 1'b0;
            kept_r    <= '0;
            k_r       <= '0;
          end
        cabn_pkg::ST_EMIT:
          k_r <= k_r + KCW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == cabn_pkg::ST_SORT_V) vscore_r <= cs_rd.score;
    if (state_r == cabn_pkg::ST_SORT_O) ord_r <= so_rd;
    if (state_r == cabn_pkg::ST_WALK_O) cur_r <= so_rd;
    if (state_r == cabn_pkg::ST_WALK_C) begin
      c_r      <= cs_rd;
      area_c_r <= 32'(cs_rd.width) * 32'(cs_rd.height);
    end
    if (state_r == cabn_pkg::ST_KEPT_CAND) begin
      ox_r     <= ovx;
      oy_r     <= ovy;
      area_p_r <= 32'(cs_rd.width) * 32'(cs_rd.height);
    end
    if (state_r == cabn_pkg::ST_IOU_MUL) inter_r <= 34'(ox_r) * 34'(oy_r);
    if (state_r == cabn_pkg::ST_IOU_UNI) begin
      uni_r <= 35'(area_c_r) + 35'(area_p_r) - 35'(inter_r);
    end
    if (state_r == cabn_pkg::ST_IOU_PROD) rhs_r <= 51'(iou_thr_r) * 51'(uni_r);
  end

endmodule

// ----- test/class_aware_box_nms_top_tb.sv -----
// Testbench for class_aware_box_nms_top: drives candidate sets through the candidate input port
// and checks every kept index against a predictor of class-aware greedy box suppression.
// Depends on cabn_pkg and the top level RTL only.
`timescale 1ns / 100ps

module class_aware_box_nms_top_tb;

  localparam int STORE_DEPTH = 256;
  localparam int KEEP_CAP    = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    cabn_pkg::cand_t cand;
    bit              last;
    bit              drain;
  } cand_item_t;

  typedef struct {
    logic [7:0] kept_index;
    logic       final_result;
    logic       overflow;
  } kept_rec_t;

  logic        clk;
  logic        rst_n;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_score = '0;
  logic [7:0]  in_obj_class = '0;
  logic [15:0] in_box_left = '0;
  logic [15:0] in_box_top = '0;
  logic [15:0] in_box_width = '0;
  logic [15:0] in_box_height = '0;
  logic        in_last_item = 1'b0;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        out_strobe;
  logic [7:0]  out_kept_index;
  logic        out_final_result;
  logic        out_overflow;

  class_aware_box_nms_top dut (.*);

  cand_item_t      pending_cands[$];
  kept_rec_t       expected_kept[$];
  cabn_pkg::cand_t stored_cands[$];
  bit              dropped_any = 1'b0;
  logic [15:0]     iou_limit;
  logic [6:0]      keep_limit_reg;
  int              mismatches = 0;
  int              results_seen = 0;
  int              sets_done = 0;
  int              cycle_count = 0;
  int              gap_left = 0;
  bit              no_idle;
  bit              finished;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] span_overlap(logic [15:0] a0, logic [15:0] alen,
                                               logic [15:0] b0, logic [15:0] blen);
    logic [63:0] a1, b1, lo, hi;
    a1 = 64'(a0) + 64'(alen);
    b1 = 64'(b0) + 64'(blen);
    lo = (a0 > b0) ? 64'(a0) : 64'(b0);
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic bit suppresses(cabn_pkg::cand_t p, cabn_pkg::cand_t q);
    logic [63:0] inter, uni;
    inter = span_overlap(p.left, p.width, q.left, q.width) *
            span_overlap(p.top, p.height, q.top, q.height);
    uni = 64'(p.width) * 64'(p.height) + 64'(q.width) * 64'(q.height) - inter;
    if (uni == 64'd0) return 1'b0;
    return (inter << 16) > 64'(iou_limit) * uni;
  endfunction

  function automatic void select_kept();
    int ord[$];
    int kept[$];
    int limit, pos;
    bit hit;
    kept_rec_t r;
    foreach (stored_cands[i]) begin
      pos = ord.size();
      while (pos > 0 && stored_cands[ord[pos-1]].score < stored_cands[i].score) pos--;
      ord.insert(pos, i);
    end
    limit = (keep_limit_reg == 0) ? 1 : int'(keep_limit_reg);
    if (limit > KEEP_CAP) limit = KEEP_CAP;
    foreach (ord[i]) begin
      if (kept.size() >= limit) break;
      hit = 1'b0;
      foreach (kept[k])
        if (stored_cands[kept[k]].obj_class == stored_cands[ord[i]].obj_class &&
            suppresses(stored_cands[ord[i]], stored_cands[kept[k]])) hit = 1'b1;
      if (!hit) kept.insert(kept.size(), ord[i]);
    end
    foreach (kept[k]) begin
      r.kept_index   = 8'(kept[k]);
      r.final_result = (k == kept.size() - 1);
      r.overflow     = dropped_any;
      expected_kept.insert(expected_kept.size(), r);
    end
    stored_cands.delete();
    dropped_any = 1'b0;
    sets_done++;
  endfunction

  function automatic void load_candidate(cabn_pkg::cand_t c, bit last);
    if (stored_cands.size() < STORE_DEPTH) stored_cands.insert(stored_cands.size(), c);
    else dropped_any = 1'b1;
    if (last) select_kept();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cand_item_t nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        load_candidate('{in_score, in_obj_class, in_box_left, in_box_top, in_box_width,
                         in_box_height}, in_last_item);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_cands.size() > 0 &&
                     !(pending_cands[0].drain && expected_kept.size() != 0)) begin
          nxt = pending_cands.pop_front();
          in_score      <= nxt.cand.score;
          in_obj_class  <= nxt.cand.obj_class;
          in_box_left   <= nxt.cand.left;
          in_box_top    <= nxt.cand.top;
          in_box_width  <= nxt.cand.width;
          in_box_height <= nxt.cand.height;
          in_last_item  <= nxt.last;
          start         <= 1'b1;
          gap_left      <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    kept_rec_t e;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_kept.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: index %0d final %0b overflow %0b",
                   out_kept_index, out_final_result, out_overflow);
      end else begin
        e = expected_kept.pop_front();
        if (e.kept_index !== out_kept_index || e.final_result !== out_final_result ||
            e.overflow !== out_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected index %0d final %0b overflow %0b, got %0d %0b %0b",
                     e.kept_index, e.final_result, e.overflow,
                     out_kept_index, out_final_result, out_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT && !finished) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_cand(logic [15:0] s, logic [7:0] cls, logic [15:0] l, logic [15:0] t,
                           logic [15:0] w, logic [15:0] h, bit last, bit drain = 1'b0);
    cand_item_t it;
    it.cand  = '{s, cls, l, t, w, h};
    it.last  = last;
    it.drain = drain;
    pending_cands.insert(pending_cands.size(), it);
  endtask

  task automatic wait_idle();
    while (pending_cands.size() != 0 || start || expected_kept.size() != 0 || busy)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == cabn_pkg::REG_IOU_THRESHOLD) iou_limit = data;
    else keep_limit_reg = data[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Clustered sets of few classes give plenty of real suppression; the rest is noise.
  task automatic push_set(int n, bit clustered, bit drain_first);
    logic [15:0] cx, cy;
    bit dr;
    cx = $urandom_range(0, 60000);
    cy = $urandom_range(0, 60000);
    for (int i = 0; i < n; i++) begin
      dr = drain_first && i == 0;
      if (clustered)
        push_cand(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 1000)
                                              : 16'($urandom),
                  8'($urandom_range(0, 2)), cx + 16'($urandom_range(0, 200)),
                  cy + 16'($urandom_range(0, 200)), 16'($urandom_range(0, 800)),
                  16'($urandom_range(0, 800)), i == n - 1, dr);
      else
        push_cand(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), i == n - 1, dr);
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    iou_limit = 16'd29491; keep_limit_reg = 7'd64;
    finished = 1'b0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_cand(16'd1000, 8'd1, 16'd0, 16'd0, 16'd160, 16'd160, 1'b0);
    push_cand(16'd900, 8'd1, 16'd16, 16'd16, 16'd160, 16'd160, 1'b0);
    push_cand(16'd900, 8'd2, 16'd16, 16'd16, 16'd160, 16'd160, 1'b0);
    push_cand(16'd1000, 8'd1, 16'd1000, 16'd1000, 16'd50, 16'd50, 1'b0);
    push_cand(16'hFFFF, 8'd1, 16'd5, 16'd5, 16'd0, 16'd0, 1'b0);
    push_cand(16'hFFFF, 8'd1, 16'd5, 16'd5, 16'd0, 16'd0, 1'b0);
    push_cand(16'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_cand(16'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_cand(16'd77, 8'd0, 16'd10, 16'd10, 16'd10, 16'd10, 1'b1);
    wait_idle();
    write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'hFFFF);
    write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd127);
    push_cand(16'd500, 8'd3, 16'd100, 16'd100, 16'd40, 16'd40, 1'b0);
    push_cand(16'd400, 8'd3, 16'd100, 16'd100, 16'd40, 16'd40, 1'b0);
    push_cand(16'd300, 8'd3, 16'd140, 16'd100, 16'd40, 16'd40, 1'b1);
    wait_idle();
    write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'd0);
    write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd0);
    push_cand(16'd10, 8'd4, 16'd0, 16'd0, 16'd20, 16'd20, 1'b0);
    push_cand(16'd20, 8'd4, 16'd20, 16'd0, 16'd20, 16'd20, 1'b0);
    push_cand(16'd20, 8'd5, 16'd0, 16'd0, 16'd20, 16'd20, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'd0);
          write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd64);
        end
        1: begin
          write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'hFFFF);
          write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd1);
        end
        2: begin
          write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'd29491);
          write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd3);
        end
        default: begin
          write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'($urandom));
          write_reg(cabn_pkg::REG_MAX_DETECTIONS,
                    16'($urandom_range(1, 64)) | 16'($urandom) & 16'hFF80);
        end
      endcase
      no_idle = (ph == 3);
      for (int s = 0; s < 4; s++)
        push_set($urandom_range(1, 12), $urandom_range(0, 4) != 0, s == 2);
      wait_idle();
    end

    // Overfill the store; the set-ending arrival is itself dropped.
    write_reg(cabn_pkg::REG_IOU_THRESHOLD, 16'd20000);
    write_reg(cabn_pkg::REG_MAX_DETECTIONS, 16'd64);
    push_set(258, 1'b1, 1'b0);
    wait_idle();

    finished = 1'b1;
    $display("Ran %0d candidate sets and checked %0d kept-index results.", sets_done,
             results_seen);
    $display("Covered thresholds and keep limits at their extremes and a store overflow.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- class_aware_box_nms_top.f -----
rtl/cabn_pkg.sv
rtl/cabn_ram.sv
rtl/class_aware_box_nms_top.sv
test/class_aware_box_nms_top_tb.sv
